### hw/rtl/u2u8_pkg.sv
`default_nettype none

package u2u8_pkg;

  localparam logic [15:0] SurrHighFirst = 16'hD800;
  localparam logic [15:0] SurrHighLast  = 16'hDBFF;
  localparam logic [15:0] SurrLowFirst  = 16'hDC00;
  localparam logic [15:0] SurrLowLast   = 16'hDFFF;
  localparam logic [20:0] SuppBase      = 21'h10000;
  localparam logic [20:0] TwoByteLimit  = 21'h00080;
  localparam logic [20:0] ThreeByteLimit = 21'h00800;
  localparam logic [20:0] FourByteLimit = 21'h10000;
  localparam logic [7:0]  LeadTwo       = 8'hC0;
  localparam logic [7:0]  LeadThree     = 8'hE0;
  localparam logic [7:0]  LeadFour      = 8'hF0;
  localparam logic [7:0]  ContMark      = 8'h80;
  localparam logic [5:0]  ContMask      = 6'h3F;

  localparam logic [1:0] LenOne   = 2'd0;
  localparam logic [1:0] LenTwo   = 2'd1;
  localparam logic [1:0] LenThree = 2'd2;
  localparam logic [1:0] LenFour  = 2'd3;

  typedef struct packed {
    logic        flush;
    logic [9:0]  flush_bits;
    logic        emit;
    logic [20:0] point;
    logic [1:0]  point_len;
    logic        last;
  } cmd_t;

  function automatic logic [1:0] seq_len(input logic [20:0] c);
    logic [1:0] len;
    if (c < TwoByteLimit) begin
      len = LenOne;
    end else if (c < ThreeByteLimit) begin
      len = LenTwo;
    end else if (c < FourByteLimit) begin
      len = LenThree;
    end else begin
      len = LenFour;
    end
    return len;
  endfunction

  function automatic logic [7:0] seq_byte(input logic [20:0] c, input logic [1:0] len,
                                          input logic [1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (len)
      LenOne: b = c[7:0];
      LenTwo: begin
        if (idx == 2'd0) b = LeadTwo | {3'b000, c[10:6]};
        else             b = ContMark | {2'b00, c[5:0] & ContMask};
      end
      LenThree: begin
        unique case (idx)
          2'd0:    b = LeadThree | {4'b0000, c[15:12]};
          2'd1:    b = ContMark | {2'b00, c[11:6] & ContMask};
          default: b = ContMark | {2'b00, c[5:0] & ContMask};
        endcase
      end
      default: begin
        unique case (idx)
          2'd0:    b = LeadFour | {5'b00000, c[20:18]};
          2'd1:    b = ContMark | {2'b00, c[17:12] & ContMask};
          2'd2:    b = ContMark | {2'b00, c[11:6] & ContMask};
          default: b = ContMark | {2'b00, c[5:0] & ContMask};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/u2u8_front.sv
`default_nettype none

module u2u8_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [15:0]   code_unit_i,
  input  wire logic          end_of_string_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output u2u8_pkg::cmd_t     cmd_o
);

  logic       held_q, held_d;
  logic [9:0] held_bits_q, held_bits_d;
  logic       accept, is_high, is_low, hold_new;

  assign is_high = (code_unit_i >= u2u8_pkg::SurrHighFirst) &&
                   (code_unit_i <= u2u8_pkg::SurrHighLast);
  assign is_low  = (code_unit_i >= u2u8_pkg::SurrLowFirst) &&
                   (code_unit_i <= u2u8_pkg::SurrLowLast);
  assign in_stall_o = q_full_i;
  assign accept = in_valid_i && !q_full_i;
  assign hold_new = is_high && !end_of_string_i;

  always_comb begin
    cmd_o.flush      = held_q && !is_low;
    cmd_o.flush_bits = held_bits_q;
    cmd_o.last       = end_of_string_i;
    if (held_q && is_low) begin
      cmd_o.emit  = 1'b1;
      cmd_o.point = u2u8_pkg::SuppBase + {1'b0, held_bits_q, code_unit_i[9:0]};
    end else begin
      cmd_o.emit  = !hold_new;
      cmd_o.point = {5'b00000, code_unit_i};
    end
    cmd_o.point_len = u2u8_pkg::seq_len(cmd_o.point);
  end

  assign push_o = accept && (cmd_o.flush || cmd_o.emit);

  always_comb begin
    held_d      = held_q;
    held_bits_d = held_bits_q;
    if (accept) begin
      held_d      = hold_new && !(held_q && is_low);
      held_bits_d = held_d ? code_unit_i[9:0] : 10'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= 1'b0;
      held_bits_q <= 10'd0;
    end else begin
      held_q      <= held_d;
      held_bits_q <= held_bits_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/u2u8_fifo.sv
`default_nettype none

module u2u8_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire u2u8_pkg::cmd_t  push_data_i,
  input  wire logic            pop_i,
  output u2u8_pkg::cmd_t       head_o,
  output logic                 full_o,
  output logic                 empty_o
);

  u2u8_pkg::cmd_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

`default_nettype wire

### hw/rtl/u2u8_back.sv
`default_nettype none

module u2u8_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire u2u8_pkg::cmd_t  head_i,
  input  wire logic            empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [7:0]           utf8_byte_o,
  output logic                 last_byte_o
);

  logic        seg_q, seg_d;
  logic [1:0]  idx_q, idx_d;
  logic        valid_q, valid_d;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d;
  logic        adv, in_flush, seg_end, entry_end;
  logic [20:0] cur_point;
  logic [1:0]  cur_len;

  assign in_flush  = head_i.flush && !seg_q;
  assign cur_point = in_flush ? {5'b00000, 6'b110110, head_i.flush_bits} : head_i.point;
  assign cur_len   = in_flush ? u2u8_pkg::LenThree : head_i.point_len;
  assign seg_end   = (idx_q == cur_len);
  assign entry_end = seg_end && (!in_flush || !head_i.emit);
  assign adv       = !empty_i && (!valid_q || !out_stall_i);
  assign pop_o     = adv && entry_end;

  always_comb begin
    seg_d   = seg_q;
    idx_d   = idx_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    if (adv) begin
      valid_d = 1'b1;
      byte_d  = u2u8_pkg::seq_byte(cur_point, cur_len, idx_q);
      last_d  = !in_flush && seg_end && head_i.last;
      if (entry_end) begin
        seg_d = 1'b0;
        idx_d = 2'd0;
      end else if (seg_end) begin
        seg_d = 1'b1;
        idx_d = 2'd0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q   <= 1'b0;
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      seg_q   <= seg_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign utf8_byte_o = byte_q;
  assign last_byte_o = last_q;

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> (idx_q <= cur_len)) else $error("byte index past sequence end");
  a_seg_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_q |-> (!empty_i && head_i.flush && head_i.emit))
    else $error("second segment without a pending flush entry");
  a_last_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && last_d) |-> pop_o) else $error("last byte sent without retiring entry");
  a_idle_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_i |-> (!seg_q && idx_q == 2'd0)) else $error("sequencer busy with empty queue");

endmodule

`default_nettype wire

### hw/rtl/utf16_to_utf8_transcoder.sv
// UTF-16 to UTF-8 transcoder.
// Input channel: in_valid_i / in_stall_o with code_unit_i and end_of_string_i;
// a beat is taken when valid is high and stall is low.
// Output channel: out_valid_o / out_stall_i with utf8_byte_o and last_byte_o,
// one byte per beat; last_byte_o marks the final byte of the string.
// A high surrogate is held until the next unit; a following low surrogate
// makes a 4-byte sequence, anything else flushes the held unit as 3 bytes.
// The front classifies units into a 2-entry command queue; the back sequencer
// emits one byte per cycle into an output register while the queue is not
// empty and the receiver does not stall. A taken unit is written into the
// queue, and its first byte is then written into the output register. A unit
// yields 1 to 4 bytes, none while a high surrogate is held, and up to 6
// when it also flushes a held surrogate.
// Input beats are taken every cycle while the queue has room.
// Reset clears the held surrogate, the queue and the output valid flag.
// When the receiver stalls, the output beat holds, the sequencer waits, the
// queue fills and then in_stall_o rises.
`default_nettype none

module utf16_to_utf8_transcoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] code_unit_i,
  input  wire logic        end_of_string_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       utf8_byte_o,
  output logic             last_byte_o
);

  u2u8_pkg::cmd_t push_cmd, head_cmd;
  logic push, pop, q_full, q_empty;

  u2u8_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .code_unit_i     (code_unit_i),
    .end_of_string_i (end_of_string_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  u2u8_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .head_o      (head_cmd),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  u2u8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .utf8_byte_o (utf8_byte_o),
    .last_byte_o (last_byte_o)
  );

endmodule

`default_nettype wire
